FILE: sv/bsdl_pkg.sv
package bsdl_pkg;

  // Field widths of the requests, results and gains
  localparam int PITCH_W = 17;
  localparam int GYRO_W = 16;
  localparam int COUNT_W = 16;
  localparam int SUMC_W = COUNT_W + 1;
  localparam int KP_W = 24;
  localparam int KD_W = 16;
  localparam int KS_W = 16;
  localparam int DRIVE_W = 14;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAL_P = 2'd0,
    CFG_BAL_D = 2'd1,
    CFG_SPEED = 2'd2
  } cfg_idx_e;

  localparam logic [KP_W-1:0] KP_RESET = KP_W'(307200);
  localparam logic [KD_W-1:0] KD_RESET = KD_W'(783);
  localparam logic [KS_W-1:0] KS_RESET = KS_W'(300);

  // Loop state and intermediate terms
  localparam int FILT_W = 26;
  localparam int INTEG_W = 23;
  localparam int SUMI_W = FILT_W + 1;
  localparam int BAL_W = 27;
  localparam int SPEED_W = 35;
  localparam int TOTAL_W = SPEED_W + 1;

  localparam int DRIVE_LIMIT = 6900;
  localparam int INTEGRAL_LIMIT = 10000;

  localparam logic signed [SUMI_W-1:0] INTEG_MAX = SUMI_W'(INTEGRAL_LIMIT * 256);
  localparam logic signed [SUMI_W-1:0] INTEG_MIN = -INTEG_MAX;
  localparam logic signed [TOTAL_W-1:0] DRIVE_MAX = TOTAL_W'(DRIVE_LIMIT);
  localparam logic signed [TOTAL_W-1:0] DRIVE_MIN = -DRIVE_MAX;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_OUT = DRIVE_W'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_OUT = -DRIVE_MAX_OUT;

  // Digit-serial multiply-accumulate
  localparam int DIG_W = 4;
  localparam int MUL_X_W = 24;
  localparam int MUL_DIGITS = MUL_X_W / DIG_W;
  localparam int MAC_A_W = 35;
  localparam int MAC_H_W = MAC_A_W + DIG_W + 2;
  localparam int PROD_W = 52;

  // Q0.16 filter coefficients and scale factors, as multiplier words
  localparam int GYRO_SHIFT = 8;
  localparam logic [MUL_X_W-1:0] FILT_KEEP_X = MUL_X_W'(55050);
  localparam logic [MUL_X_W-1:0] FILT_TAKE_X = MUL_X_W'(10486 * 256);
  localparam logic [MUL_X_W-1:0] SPEED_SCALE_X = MUL_X_W'(200);
  localparam logic [MUL_X_W-1:0] UNIT_X = MUL_X_W'(1);

  // Q.16 product back to integer
  localparam int FRAC_SH = 16;
  localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_SH) - 1);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_SH - 1));

  // Speed division: /51200 = >>10 then /50, one digit a cycle
  localparam int DIV_SHIFT = 10;
  localparam int DIV_CONST = 50;
  localparam int DIV_R_W = $clog2(DIV_CONST);
  localparam int DIV_N_W = 40;
  localparam int DIV_DIGITS = DIV_N_W / DIG_W;

  typedef struct packed {
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_A_W-1:0] b;
    logic [MUL_X_W-1:0]        x;
    logic [MUL_X_W-1:0]        y;
  } mac_op_t;

endpackage

FILE: sv/bsdl_if.sv
interface bsdl_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bsdl_pkg::PITCH_W-1:0]    pitch_q8;
  logic signed [bsdl_pkg::GYRO_W-1:0]     gyro_rate;
  logic signed [bsdl_pkg::COUNT_W-1:0]    left_count;
  logic signed [bsdl_pkg::COUNT_W-1:0]    right_count;

  modport source (output valid, pitch_q8, gyro_rate, left_count, right_count, input ready);
  modport sink (input valid, pitch_q8, gyro_rate, left_count, right_count, output ready);
endinterface

interface bsdl_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bsdl_pkg::DRIVE_W-1:0]    motor_drive;
  logic                                   drive_saturated;

  modport source (output valid, motor_drive, drive_saturated, input ready);
  modport sink (input valid, motor_drive, drive_saturated, output ready);
endinterface

interface bsdl_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [bsdl_pkg::CFG_IDX_W-1:0]         addr;
  logic [bsdl_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: sv/bsdl_mac.sv
// Two-lane digit-serial multiply-accumulate: a*x + b*y, x and y unsigned.
// One digit of each multiplier per cycle; the accumulator shifts right and
// retired low digits collect in l_q, so the adder stays one operand wide.
module bsdl_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  bsdl_pkg::mac_op_t                     op_i,
  output logic signed [bsdl_pkg::PROD_W-1:0]    prod_o,
  output logic                                  done_o
);

  localparam int CNT_W = $clog2(bsdl_pkg::MUL_DIGITS);
  localparam int PA_W = bsdl_pkg::MAC_A_W + bsdl_pkg::DIG_W + 1;

  logic signed [bsdl_pkg::MAC_A_W-1:0] a_q, b_q;
  logic [bsdl_pkg::MUL_X_W-1:0]        x_q, y_q, l_q;
  logic signed [bsdl_pkg::MAC_H_W-1:0] h_q, t;
  logic signed [PA_W-1:0]              pa, pb;
  logic [CNT_W-1:0]                    cnt_q;
  logic                                busy_q, done_q;

  // Partial products of the current digits, added to the running sum
  always_comb begin
    pa = a_q * $signed({1'b0, x_q[bsdl_pkg::DIG_W-1:0]});
    pb = b_q * $signed({1'b0, y_q[bsdl_pkg::DIG_W-1:0]});
    t  = h_q + bsdl_pkg::MAC_H_W'(pa) + bsdl_pkg::MAC_H_W'(pb);
  end

  // Sequence the digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(bsdl_pkg::MUL_DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift one digit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= op_i.a;
      b_q <= op_i.b;
      x_q <= op_i.x;
      y_q <= op_i.y;
      h_q <= '0;
      l_q <= '0;
    end else if (busy_q) begin
      h_q <= t >>> bsdl_pkg::DIG_W;
      l_q <= {t[bsdl_pkg::DIG_W-1:0], l_q[bsdl_pkg::MUL_X_W-1:bsdl_pkg::DIG_W]};
      x_q <= x_q >> bsdl_pkg::DIG_W;
      y_q <= y_q >> bsdl_pkg::DIG_W;
    end
  end

  assign prod_o = $signed({h_q[bsdl_pkg::PROD_W-bsdl_pkg::MUL_X_W-1:0], l_q});
  assign done_o = done_q;

endmodule

FILE: sv/bsdl_div.sv
// Digit-serial division of an unsigned word by a small constant: one
// quotient digit per cycle, the remainder never wider than the divisor.
module bsdl_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [bsdl_pkg::DIV_N_W-1:0]    dividend_i,
  output logic [bsdl_pkg::DIV_N_W-1:0]    quot_o,
  output logic                            done_o
);

  localparam int CNT_W = $clog2(bsdl_pkg::DIV_DIGITS);
  localparam int RT_W = bsdl_pkg::DIV_R_W + 1;
  localparam logic [RT_W-1:0] DIVISOR = RT_W'(bsdl_pkg::DIV_CONST);

  logic [bsdl_pkg::DIV_N_W-1:0] n_q, q_q;
  logic [bsdl_pkg::DIV_R_W-1:0] r_q, r_w;
  logic [RT_W-1:0]              r_t;
  logic [bsdl_pkg::DIG_W-1:0]   qd;
  logic [CNT_W-1:0]             cnt_q;
  logic                         busy_q, done_q;

  // Restoring steps for one digit
  always_comb begin
    r_w = r_q;
    r_t = '0;
    qd  = '0;
    for (int i = 0; i < bsdl_pkg::DIG_W; i++) begin
      r_t = {r_w, n_q[bsdl_pkg::DIV_N_W-1-i]};
      if (r_t >= DIVISOR) begin
        r_t = r_t - DIVISOR;
        qd[bsdl_pkg::DIG_W-1-i] = 1'b1;
      end
      r_w = r_t[bsdl_pkg::DIV_R_W-1:0];
    end
  end

  // Sequence the digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(bsdl_pkg::DIV_DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out and the quotient in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= dividend_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      n_q <= n_q << bsdl_pkg::DIG_W;
      r_q <= r_w;
      q_q <= {q_q[bsdl_pkg::DIV_N_W-bsdl_pkg::DIG_W-1:0], qd};
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

FILE: sv/balance_and_speed_drive_loop.sv
// Channel  Role    Handshake        Carries
// in_i     sink    valid / ready    pitch_q8, gyro_rate, left_count, right_count
// out_o    source  valid / ready    motor_drive, drive_saturated
// cfg_i    sink    valid / ready    addr (gain index), data
//
// A request runs through four passes of the shared multiply-accumulate unit
// (six multiplier digits each) and a ten-digit divide; its result is loaded
// in the summing step, and the next request is taken once it is back in idle.
// in_i is ready only while no request is in work; a waiting result does not
// block it, but a new result is held back until out_o has taken the old one.
// Reset restores the gains and clears the speed filter and integral.
// cfg_i is always ready.
module balance_and_speed_drive_loop (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsdl_in_if.sink       in_i,
  bsdl_out_if.source    out_o,
  bsdl_cfg_if.sink      cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAL,
    ST_FILT,
    ST_INTEG,
    ST_PSUM,
    ST_SPEED,
    ST_DIV,
    ST_SUM
  } state_e;

  state_e state_q;

  logic [bsdl_pkg::KP_W-1:0] kp_q;
  logic [bsdl_pkg::KD_W-1:0] kd_q;
  logic [bsdl_pkg::KS_W-1:0] ks_q;

  logic signed [bsdl_pkg::SUMC_W-1:0]  s_q;
  logic signed [bsdl_pkg::BAL_W-1:0]   bal_q;
  logic signed [bsdl_pkg::FILT_W-1:0]  filt_q, filt_new;
  logic signed [bsdl_pkg::INTEG_W-1:0] integ_q, integ_new;
  logic signed [bsdl_pkg::SPEED_W-1:0] spd_q, spd_new;
  logic                                neg_q;
  logic                                out_valid_q, out_sat_q;
  logic signed [bsdl_pkg::DRIVE_W-1:0] out_drive_q;

  logic                                in_acc, out_free;
  logic                                mac_start, mac_done, div_start, div_done;
  bsdl_pkg::mac_op_t                   mac_op;
  logic signed [bsdl_pkg::PROD_W-1:0]  mac_prod;
  logic [bsdl_pkg::PROD_W-1:0]         bal_tmp, filt_tmp, prod_mag;
  logic [bsdl_pkg::DIV_N_W-1:0]        div_quot;
  logic [bsdl_pkg::SPEED_W-1:0]        quot_cut;
  logic signed [bsdl_pkg::SUMI_W-1:0]  isum;
  logic signed [bsdl_pkg::TOTAL_W-1:0] total;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready            = (state_q == ST_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign out_o.valid           = out_valid_q;
  assign out_o.motor_drive     = out_drive_q;
  assign out_o.drive_saturated = out_sat_q;

  // Pick operands for each multiply-accumulate pass
  always_comb begin
    mac_start = 1'b0;
    mac_op    = '0;
    case (state_q)
      ST_IDLE: begin
        mac_start = in_acc;
        mac_op.a  = bsdl_pkg::MAC_A_W'(in_i.pitch_q8);
        mac_op.b  = bsdl_pkg::MAC_A_W'(in_i.gyro_rate);
        mac_op.x  = kp_q;
        mac_op.y  = bsdl_pkg::MUL_X_W'(kd_q) << bsdl_pkg::GYRO_SHIFT;
      end
      ST_BAL: begin
        mac_start = mac_done;
        mac_op.a  = bsdl_pkg::MAC_A_W'(filt_q);
        mac_op.b  = bsdl_pkg::MAC_A_W'(s_q);
        mac_op.x  = bsdl_pkg::FILT_KEEP_X;
        mac_op.y  = bsdl_pkg::FILT_TAKE_X;
      end
      ST_INTEG: begin
        mac_start = 1'b1;
        mac_op.a  = bsdl_pkg::MAC_A_W'(filt_q);
        mac_op.b  = bsdl_pkg::MAC_A_W'(integ_new);
        mac_op.x  = bsdl_pkg::SPEED_SCALE_X;
        mac_op.y  = bsdl_pkg::UNIT_X;
      end
      ST_PSUM: begin
        mac_start = mac_done;
        mac_op.a  = mac_prod[bsdl_pkg::MAC_A_W-1:0];
        mac_op.x  = bsdl_pkg::MUL_X_W'(ks_q);
      end
      default: begin
        mac_start = 1'b0;
      end
    endcase
  end

  bsdl_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .op_i    (mac_op),
    .prod_o  (mac_prod),
    .done_o  (mac_done)
  );

  // Balance: truncate toward zero; filter: round half up
  always_comb begin
    bal_tmp  = mac_prod + (mac_prod[bsdl_pkg::PROD_W-1] ? bsdl_pkg::TRUNC_BIAS : '0);
    filt_tmp = mac_prod + bsdl_pkg::ROUND_HALF;
    filt_new = filt_tmp[bsdl_pkg::FRAC_SH+bsdl_pkg::FILT_W-1:bsdl_pkg::FRAC_SH];
  end

  // Integrate the new filter value and clamp
  always_comb begin
    isum = bsdl_pkg::SUMI_W'(integ_q) + bsdl_pkg::SUMI_W'(filt_q);
    if (isum > bsdl_pkg::INTEG_MAX) begin
      integ_new = bsdl_pkg::INTEG_MAX[bsdl_pkg::INTEG_W-1:0];
    end else if (isum < bsdl_pkg::INTEG_MIN) begin
      integ_new = bsdl_pkg::INTEG_MIN[bsdl_pkg::INTEG_W-1:0];
    end else begin
      integ_new = isum[bsdl_pkg::INTEG_W-1:0];
    end
  end

  // Divide the speed product magnitude, then restore the sign
  assign prod_mag  = mac_prod[bsdl_pkg::PROD_W-1] ? -mac_prod : mac_prod;
  assign div_start = (state_q == ST_SPEED) && mac_done;
  assign quot_cut  = div_quot[bsdl_pkg::SPEED_W-1:0];
  assign spd_new   = neg_q ? -quot_cut : quot_cut;

  bsdl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag[bsdl_pkg::DIV_SHIFT+bsdl_pkg::DIV_N_W-1:bsdl_pkg::DIV_SHIFT]),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  assign total = bsdl_pkg::TOTAL_W'(bal_q) + bsdl_pkg::TOTAL_W'(spd_q);

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= bsdl_pkg::KP_RESET;
      kd_q <= bsdl_pkg::KD_RESET;
      ks_q <= bsdl_pkg::KS_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (bsdl_pkg::cfg_idx_e'(cfg_i.addr))
        bsdl_pkg::CFG_BAL_P: kp_q <= cfg_i.data[bsdl_pkg::KP_W-1:0];
        bsdl_pkg::CFG_BAL_D: kd_q <= cfg_i.data[bsdl_pkg::KD_W-1:0];
        bsdl_pkg::CFG_SPEED: ks_q <= cfg_i.data[bsdl_pkg::KS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, loop state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      filt_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
      out_drive_q <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once taken
      if ((state_q == ST_SUM) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) state_q <= ST_BAL;
        end
        ST_BAL: begin
          if (mac_done) state_q <= ST_FILT;
        end
        ST_FILT: begin
          if (mac_done) begin
            filt_q  <= filt_new;
            state_q <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integ_q <= integ_new;
          state_q <= ST_PSUM;
        end
        ST_PSUM: begin
          if (mac_done) state_q <= ST_SPEED;
        end
        ST_SPEED: begin
          if (mac_done) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (out_free) begin
            if (total > bsdl_pkg::DRIVE_MAX) begin
              out_drive_q <= bsdl_pkg::DRIVE_MAX[bsdl_pkg::DRIVE_W-1:0];
              out_sat_q   <= 1'b1;
            end else if (total < bsdl_pkg::DRIVE_MIN) begin
              out_drive_q <= bsdl_pkg::DRIVE_MIN[bsdl_pkg::DRIVE_W-1:0];
              out_sat_q   <= 1'b1;
            end else begin
              out_drive_q <= total[bsdl_pkg::DRIVE_W-1:0];
              out_sat_q   <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Hold intermediate terms between passes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q <= bsdl_pkg::SUMC_W'(in_i.left_count) + bsdl_pkg::SUMC_W'(in_i.right_count);
    end
    if ((state_q == ST_BAL) && mac_done) begin
      bal_q <= bal_tmp[bsdl_pkg::FRAC_SH+bsdl_pkg::BAL_W-1:bsdl_pkg::FRAC_SH];
    end
    if (div_start) begin
      neg_q <= mac_prod[bsdl_pkg::PROD_W-1];
    end
    if ((state_q == ST_DIV) && div_done) begin
      spd_q <= spd_new;
    end
  end

  // An accepted request always starts the balance pass
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_BAL))
    else $error("request accepted but balance pass not started");

  // The integral never leaves its clamp range
  a_integ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= bsdl_pkg::INTEG_MAX) && (integ_q >= bsdl_pkg::INTEG_MIN))
    else $error("speed integral outside its limit");

  // A new result appears only from the summing step
  a_load_from_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SUM))
    else $error("result loaded outside the summing step");

  // A saturated result sits exactly on a limit
  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |->
      ((out_drive_q == bsdl_pkg::DRIVE_MAX_OUT) || (out_drive_q == bsdl_pkg::DRIVE_MIN_OUT)))
    else $error("saturated drive not at the limit");

endmodule
